// ===== rtl/tasg_pkg.sv =====
// Shared constants, types and helpers for the tensor axis swap address generator.
`default_nettype none

package tasg_pkg;

    localparam int MAX_RANK_DEF   = 4;
    localparam int ADDR_WIDTH_DEF = 32;

    localparam int NUM_SIZE_REGS = 4;
    localparam int CNT_W         = 8;
    localparam int EXT_W         = 9;
    // The running stride product reaches the product of all four axis extents (up to 2^32).
    localparam int PROD_W        = NUM_SIZE_REGS * CNT_W + 1;
    localparam int ELEM_W        = 32;
    localparam int OUT_ADDR_W    = 32;
    localparam int RANK_W        = 3;
    localparam int AXIS_W        = 3;
    localparam int EFF_RANK_W    = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 9;
    localparam int MAX_EXTENT    = 256;

    localparam logic [RANK_W-1:0] RANK_RST        = RANK_W'(2);
    localparam logic [EXT_W-1:0]  SIZE_RST        = EXT_W'(1);
    localparam logic [AXIS_W-1:0] SWAP_FIRST_RST  = AXIS_W'(0);
    localparam logic [AXIS_W-1:0] SWAP_SECOND_RST = AXIS_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK        = 3'd0,
        REG_SIZE_AXIS0  = 3'd1,
        REG_SIZE_AXIS1  = 3'd2,
        REG_SIZE_AXIS2  = 3'd3,
        REG_SIZE_AXIS3  = 3'd4,
        REG_SWAP_FIRST  = 3'd5,
        REG_SWAP_SECOND = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PROD,
        SEQ_DELTA
    } seq_state_t;

    function automatic logic [EXT_W-1:0] clamp_size(input logic [EXT_W-1:0] raw);
        logic [EXT_W-1:0] s;
        s = raw;
        if (raw == '0)
            s = EXT_W'(1);
        else if (raw > EXT_W'(MAX_EXTENT))
            s = EXT_W'(MAX_EXTENT);
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tensor_axis_swap_address_gen_top.sv =====
// Streaming address generator for a tensor with two axes swapped.
// Result registered in the cycle after the input transaction; one element per cycle while in_ready is high.
// Output register decouples sides: input taken whenever the result slot is free or draining.
// After reset and after every write to a mapped register, a pass derives the per-axis
// address steps (one multiply per cycle); in_ready stays low during that pass.
// Reset (rst_n, async): rank 2, sizes 1, swap axes 0 and 1, counters and address at zero.
`default_nettype none

module tensor_axis_swap_address_gen_top #(
    parameter int MAX_RANK   = tasg_pkg::MAX_RANK_DEF,
    parameter int ADDR_WIDTH = tasg_pkg::ADDR_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  [tasg_pkg::ELEM_W-1:0]           element_bits,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [tasg_pkg::OUT_ADDR_W-1:0]       dest_address,
    output logic [tasg_pkg::ELEM_W-1:0]           element_out,
    output logic                                  last_element,
    output logic                                  axis_error,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [tasg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [tasg_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int AXW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CNT_W = tasg_pkg::CNT_W;
    localparam int EXT_W = tasg_pkg::EXT_W;
    localparam int PROD_W = tasg_pkg::PROD_W;

    // configuration registers
    logic [tasg_pkg::RANK_W-1:0] rank_reg;
    logic [EXT_W-1:0]            size_reg [tasg_pkg::NUM_SIZE_REGS];
    logic [tasg_pkg::AXIS_W-1:0] swap_first_reg;
    logic [tasg_pkg::AXIS_W-1:0] swap_second_reg;

    logic cfg_write;
    logic cfg_known;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (tasg_pkg::cfg_reg_t'(cfg_index))
            tasg_pkg::REG_RANK,
            tasg_pkg::REG_SIZE_AXIS0,
            tasg_pkg::REG_SIZE_AXIS1,
            tasg_pkg::REG_SIZE_AXIS2,
            tasg_pkg::REG_SIZE_AXIS3,
            tasg_pkg::REG_SWAP_FIRST,
            tasg_pkg::REG_SWAP_SECOND: cfg_known = 1'b1;
            default:                   cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg        <= tasg_pkg::RANK_RST;
            for (int i = 0; i < tasg_pkg::NUM_SIZE_REGS; i++)
                size_reg[i] <= tasg_pkg::SIZE_RST;
            swap_first_reg  <= tasg_pkg::SWAP_FIRST_RST;
            swap_second_reg <= tasg_pkg::SWAP_SECOND_RST;
        end
        else if (cfg_write)
        begin
            unique case (tasg_pkg::cfg_reg_t'(cfg_index))
                tasg_pkg::REG_RANK:        rank_reg        <= cfg_data[tasg_pkg::RANK_W-1:0];
                tasg_pkg::REG_SIZE_AXIS0:  size_reg[0]     <= cfg_data;
                tasg_pkg::REG_SIZE_AXIS1:  size_reg[1]     <= cfg_data;
                tasg_pkg::REG_SIZE_AXIS2:  size_reg[2]     <= cfg_data;
                tasg_pkg::REG_SIZE_AXIS3:  size_reg[3]     <= cfg_data;
                tasg_pkg::REG_SWAP_FIRST:  swap_first_reg  <= cfg_data[tasg_pkg::AXIS_W-1:0];
                tasg_pkg::REG_SWAP_SECOND: swap_second_reg <= cfg_data[tasg_pkg::AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective rank, axis extents, normalized swap axes
    logic [tasg_pkg::EFF_RANK_W-1:0] eff_rank;
    logic [EXT_W-1:0]                ext [MAX_RANK];
    logic [EXT_W-1:0]                od  [MAX_RANK];
    logic [AXW-1:0]                  perm [MAX_RANK];
    logic [AXW-1:0]                  ax_a, ax_b;
    logic                            ok_a, ok_b, swap_ok;

    always_comb
    begin
        if (rank_reg == '0)
            eff_rank = tasg_pkg::EFF_RANK_W'(1);
        else if ({1'b0, rank_reg} > tasg_pkg::EFF_RANK_W'(MAX_RANK))
            eff_rank = tasg_pkg::EFF_RANK_W'(MAX_RANK);
        else
            eff_rank = {1'b0, rank_reg};
    end

    for (genvar g = 0; g < MAX_RANK; g++)
    begin : g_ext
        if (g < tasg_pkg::NUM_SIZE_REGS)
        begin : g_sized
            assign ext[g] = (tasg_pkg::EFF_RANK_W'(g) < eff_rank) ?
                            tasg_pkg::clamp_size(size_reg[g]) : EXT_W'(1);
        end
        else
        begin : g_unit
            assign ext[g] = EXT_W'(1);
        end
    end

    function automatic logic norm_axis(input logic [tasg_pkg::AXIS_W-1:0] raw,
                                       input logic [tasg_pkg::EFF_RANK_W-1:0] r,
                                       output logic [AXW-1:0] ax);
        logic signed [4:0] v;
        logic signed [4:0] rs;
        rs = signed'({1'b0, r});
        v  = signed'({{2{raw[2]}}, raw});
        if (raw[2])
            v = v + rs;
        ax = v[AXW-1:0];
        return (v >= 5'sd0) && (v < rs);
    endfunction

    always_comb
    begin
        ok_a    = norm_axis(swap_first_reg, eff_rank, ax_a);
        ok_b    = norm_axis(swap_second_reg, eff_rank, ax_b);
        swap_ok = ok_a && ok_b;
        for (int i = 0; i < MAX_RANK; i++)
        begin
            if (swap_ok && AXW'(i) == ax_a)
            begin
                od[i]   = ext[ax_b];
                perm[i] = ax_b;
            end
            else if (swap_ok && AXW'(i) == ax_b)
            begin
                od[i]   = ext[ax_a];
                perm[i] = ax_a;
            end
            else
            begin
                od[i]   = ext[i];
                perm[i] = AXW'(i);
            end
        end
    end

    // step sequencer: output-order strides, then per-axis address deltas
    tasg_pkg::seq_state_t seq_state_reg, seq_state_next;
    logic [AXW-1:0]        idx_reg, idx_next;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     os_reg [MAX_RANK];
    logic [ADDR_WIDTH-1:0] back_reg;
    logic [ADDR_WIDTH-1:0] delta_reg [MAX_RANK];
    logic [ADDR_WIDTH-1:0] stride_cur;
    logic [CNT_W-1:0]      span_cur;
    logic [PROD_W+ADDR_WIDTH-1:0] os_wide;
    logic [EXT_W+PROD_W-1:0]      prod_mul;
    logic [CNT_W+ADDR_WIDTH-1:0]  back_mul;
    logic                         seq_busy;

    always_comb
    begin
        seq_state_next = seq_state_reg;
        idx_next       = idx_reg;
        if (cfg_write && cfg_known)
        begin
            seq_state_next = tasg_pkg::SEQ_PROD;
            idx_next       = AXW'(MAX_RANK - 1);
        end
        else
        begin
            unique case (seq_state_reg)
                tasg_pkg::SEQ_IDLE: ;
                tasg_pkg::SEQ_PROD:
                begin
                    if (idx_reg == '0)
                    begin
                        seq_state_next = tasg_pkg::SEQ_DELTA;
                        idx_next       = AXW'(MAX_RANK - 1);
                    end
                    else
                        idx_next = idx_reg - AXW'(1);
                end
                tasg_pkg::SEQ_DELTA:
                begin
                    if (idx_reg == '0)
                        seq_state_next = tasg_pkg::SEQ_IDLE;
                    else
                        idx_next = idx_reg - AXW'(1);
                end
                default: seq_state_next = tasg_pkg::SEQ_IDLE;
            endcase
        end
    end

    always_comb
    begin
        seq_busy   = (seq_state_reg != tasg_pkg::SEQ_IDLE);
        prod_mul   = prod_reg * od[idx_reg];
        os_wide    = {{ADDR_WIDTH{1'b0}}, os_reg[perm[idx_reg]]};
        stride_cur = os_wide[ADDR_WIDTH-1:0];
        // extent 256 wraps to 0 in 8 bits, so the subtract yields 255
        span_cur   = ext[idx_reg][CNT_W-1:0] - CNT_W'(1);
        back_mul   = {{ADDR_WIDTH{1'b0}}, span_cur} * {{CNT_W{1'b0}}, stride_cur};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= tasg_pkg::SEQ_PROD;
            idx_reg       <= AXW'(MAX_RANK - 1);
            prod_reg      <= PROD_W'(1);
            back_reg      <= '0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            idx_reg       <= idx_next;
            if (cfg_write && cfg_known)
            begin
                prod_reg <= PROD_W'(1);
                back_reg <= '0;
            end
            else if (seq_state_reg == tasg_pkg::SEQ_PROD)
                prod_reg <= prod_mul[PROD_W-1:0];
            else if (seq_state_reg == tasg_pkg::SEQ_DELTA)
                back_reg <= back_reg + back_mul[ADDR_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!(cfg_write && cfg_known))
        begin
            if (seq_state_reg == tasg_pkg::SEQ_PROD)
                os_reg[idx_reg] <= prod_reg;
            else if (seq_state_reg == tasg_pkg::SEQ_DELTA)
                delta_reg[idx_reg] <= stride_cur - back_reg;
        end
    end

    // element stream: mixed-radix counter and incremental address
    logic [CNT_W-1:0]      cnt_reg  [MAX_RANK];
    logic [CNT_W-1:0]      cnt_next [MAX_RANK];
    logic [ADDR_WIDTH-1:0] acc_reg, acc_next;
    logic [AXW-1:0]        sel;
    logic                  all_max;
    logic                  cnt_ok;
    logic                  in_accept;
    logic [ADDR_WIDTH+tasg_pkg::OUT_ADDR_W-1:0] acc_wide;

    logic                            out_valid_reg;
    logic [tasg_pkg::OUT_ADDR_W-1:0] dest_address_reg;
    logic [tasg_pkg::ELEM_W-1:0]     element_out_reg;
    logic                            last_element_reg;
    logic                            axis_error_reg;

    assign in_ready  = !seq_busy && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        all_max = 1'b1;
        cnt_ok  = 1'b1;
        sel     = '0;
        // innermost axis not at its last index takes the carry
        for (int i = 0; i < MAX_RANK; i++)
        begin
            if ({1'b0, cnt_reg[i]} != ext[i] - EXT_W'(1))
            begin
                all_max = 1'b0;
                sel     = AXW'(i);
            end
            if ({1'b0, cnt_reg[i]} >= ext[i])
                cnt_ok = 1'b0;
        end
        for (int i = 0; i < MAX_RANK; i++)
        begin
            if (all_max || AXW'(i) > sel)
                cnt_next[i] = '0;
            else if (AXW'(i) == sel)
                cnt_next[i] = cnt_reg[i] + CNT_W'(1);
            else
                cnt_next[i] = cnt_reg[i];
        end
        acc_next = all_max ? '0 : acc_reg + delta_reg[sel];
        acc_wide = {{tasg_pkg::OUT_ADDR_W{1'b0}}, acc_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RANK; i++)
                cnt_reg[i] <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_known)
            begin
                for (int i = 0; i < MAX_RANK; i++)
                    cnt_reg[i] <= '0;
                acc_reg <= '0;
            end
            else if (in_accept)
            begin
                cnt_reg <= cnt_next;
                acc_reg <= acc_next;
            end
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dest_address_reg <= acc_wide[tasg_pkg::OUT_ADDR_W-1:0];
            element_out_reg  <= element_bits;
            last_element_reg <= all_max;
            axis_error_reg   <= !swap_ok;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_address = dest_address_reg;
    assign element_out  = element_out_reg;
    assign last_element = last_element_reg;
    assign axis_error   = axis_error_reg;

    // a write to a mapped register restarts the derivation pass and the element counter
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && cfg_known |=> seq_state_reg == tasg_pkg::SEQ_PROD && acc_reg == '0)
        else $error("register write did not restart derivation");

    // no element is taken while address steps are being derived
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy |-> !in_ready)
        else $error("input taken during derivation pass");

    // counter digits stay below their extents once configuration settles
    assert property (@(posedge clk) disable iff (!rst_n)
        !seq_busy |-> cnt_ok)
        else $error("axis counter out of range");

    // the final element wraps the address back to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && all_max && !cfg_write |=> acc_reg == '0 && last_element)
        else $error("address not restarted after last element");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for tensor_axis_swap_address_gen_top: streams elements, predicts addresses.
`timescale 1ns / 1ps

module tb;

    localparam int AXES           = tasg_pkg::MAX_RANK_DEF;
    localparam int CFG_IDX_W      = tasg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = tasg_pkg::CFG_DATA_W;
    localparam int OUT_ADDR_W     = tasg_pkg::OUT_ADDR_W;
    localparam int ELEM_W         = tasg_pkg::ELEM_W;
    localparam int RANK_W         = tasg_pkg::RANK_W;
    localparam int EXT_W          = tasg_pkg::EXT_W;
    localparam int AXIS_W         = tasg_pkg::AXIS_W;
    localparam int CNT_W          = tasg_pkg::CNT_W;
    localparam int MAX_EXTENT     = tasg_pkg::MAX_EXTENT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 450;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(7);

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        logic [ELEM_W-1:0]     elem;
        logic                  last;
        logic                  err;
    } remap_result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ELEM_W-1:0]     element_bits;
    logic                  out_valid;
    logic                  out_ready;
    logic [OUT_ADDR_W-1:0] dest_address;
    logic [ELEM_W-1:0]     element_out;
    logic                  last_element;
    logic                  axis_error;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tensor_axis_swap_address_gen_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .element_bits (element_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dest_address (dest_address),
        .element_out  (element_out),
        .last_element (last_element),
        .axis_error   (axis_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state: register shadow, axis counters, address and strides
    logic [RANK_W-1:0]     shadow_rank;
    logic [EXT_W-1:0]      shadow_size [AXES];
    logic [AXIS_W-1:0]     shadow_swap_a;
    logic [AXIS_W-1:0]     shadow_swap_b;
    logic [CNT_W-1:0]      axis_idx [AXES];
    logic [OUT_ADDR_W-1:0] addr_acc;
    logic [OUT_ADDR_W-1:0] dest_stride [AXES];
    logic                  swap_err;

    remap_result_t dest_addr_q[$];
    reg_write_t    reg_writes[$];

    int   errors      = 0;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    int   ready_stall = 0;
    bit   gaps_on     = 1'b1;
    logic hold_active;
    event hold_start;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int eff_rank();
        int r;
        r = int'(shadow_rank);
        if (r == 0) r = 1;
        if (r > AXES) r = AXES;
        return r;
    endfunction

    function automatic int axis_extent(int i);
        int s;
        if (i >= eff_rank()) return 1;
        s = int'(shadow_size[i]);
        if (s == 0) s = 1;
        if (s > MAX_EXTENT) s = MAX_EXTENT;
        return s;
    endfunction

    function automatic longint tensor_elements();
        longint n;
        n = 1;
        for (int i = 0; i < AXES; i++) n = n * axis_extent(i);
        return n;
    endfunction

    // negative axis counts from the end; returns 0 when outside 0..r-1
    function automatic bit norm_axis(logic [AXIS_W-1:0] raw, int r, output int ax);
        int v;
        v  = int'($signed(raw));
        ax = 0;
        if (v < 0) v += r;
        if (v < 0 || v >= r) return 1'b0;
        ax = v;
        return 1'b1;
    endfunction

    function automatic void rebuild_strides();
        int              r;
        int              a;
        int              b;
        bit              ok_a;
        bit              ok_b;
        longint unsigned ext [AXES];
        longint unsigned lin [AXES];
        longint unsigned t;
        int              perm [AXES];
        r        = eff_rank();
        ok_a     = norm_axis(shadow_swap_a, r, a);
        ok_b     = norm_axis(shadow_swap_b, r, b);
        swap_err = !(ok_a && ok_b);
        for (int i = 0; i < AXES; i++)
        begin
            ext[i]  = axis_extent(i);
            perm[i] = i;
        end
        // bad axis: no swap, plain row-major address
        if (!swap_err)
        begin
            t       = ext[a];
            ext[a]  = ext[b];
            ext[b]  = t;
            perm[a] = b;
            perm[b] = a;
        end
        lin[AXES-1] = 1;
        for (int i = AXES - 2; i >= 0; i--)
            lin[i] = (lin[i+1] * ext[i+1]) & 64'hFFFF_FFFF_FFFF;
        for (int i = 0; i < AXES; i++)
        begin
            dest_stride[i] = OUT_ADDR_W'(lin[perm[i]]);
            axis_idx[i]    = '0;
        end
        addr_acc = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            tasg_pkg::REG_RANK:        shadow_rank    = data[RANK_W-1:0];
            tasg_pkg::REG_SIZE_AXIS0:  shadow_size[0] = data;
            tasg_pkg::REG_SIZE_AXIS1:  shadow_size[1] = data;
            tasg_pkg::REG_SIZE_AXIS2:  shadow_size[2] = data;
            tasg_pkg::REG_SIZE_AXIS3:  shadow_size[3] = data;
            tasg_pkg::REG_SWAP_FIRST:  shadow_swap_a  = data[AXIS_W-1:0];
            tasg_pkg::REG_SWAP_SECOND: shadow_swap_b  = data[AXIS_W-1:0];
            default:                   return;
        endcase
        rebuild_strides();
    endfunction

    function automatic remap_result_t predict_remap(logic [ELEM_W-1:0] elem);
        remap_result_t         res;
        bit                    at_end;
        int                    nxt;
        logic [OUT_ADDR_W-1:0] acc;
        at_end = 1'b1;
        for (int i = 0; i < AXES; i++)
            if (int'(axis_idx[i]) != axis_extent(i) - 1) at_end = 1'b0;
        res.addr = addr_acc;
        res.elem = elem;
        res.last = at_end;
        res.err  = swap_err;
        // row-major advance, innermost axis first; wraps to zero after the last element
        for (int i = AXES - 1; i >= 0; i--)
        begin
            nxt = int'(axis_idx[i]) + 1;
            if (nxt < axis_extent(i))
            begin
                axis_idx[i] = CNT_W'(nxt);
                break;
            end
            axis_idx[i] = '0;
        end
        acc = '0;
        for (int i = 0; i < AXES; i++)
            acc = acc + OUT_ADDR_W'(axis_idx[i]) * dest_stride[i];
        addr_acc = acc;
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_reg_value(logic [CFG_IDX_W-1:0] idx);
        int pick;
        pick = $urandom_range(0, 9);
        case (idx)
            tasg_pkg::REG_SIZE_AXIS0, tasg_pkg::REG_SIZE_AXIS1,
            tasg_pkg::REG_SIZE_AXIS2, tasg_pkg::REG_SIZE_AXIS3:
            begin
                // mostly tiny extents so whole tensors complete often
                if (pick < 8) return CFG_DATA_W'($urandom_range(1, 3));
                if (pick == 8) return CFG_DATA_W'(MAX_EXTENT);
            end
            default: ;
        endcase
        return CFG_DATA_W'($urandom);
    endfunction

    // valid is left high after a transaction; any caller that does not send next lowers it
    task automatic send_element(logic [ELEM_W-1:0] data);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        element_bits <= data;
        do @(posedge clk); while (!in_ready);
        dest_addr_q.push_back(predict_remap(data));
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (dest_addr_q.size() != 0) @(posedge clk);
    endtask

    // writes every staged register back to back while the stream is idle
    task automatic program_regs();
        reg_write_t w;
        wait_drained();
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            do @(posedge clk); while (!cfg_ready);
            apply_reg(w.idx, w.data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        remap_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (dest_addr_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual addr %h elem %h",
                         $time, dest_address, element_out);
            end
            else
            begin
                exp_r = dest_addr_q.pop_front();
                check_field("dest_address", exp_r.addr, dest_address);
                check_field("element_out", exp_r.elem, element_out);
                check_field("last_element", 32'(exp_r.last), 32'(last_element));
                check_field("axis_error", 32'(exp_r.err), 32'(axis_error));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_active)
        begin
            out_ready <= 1'b0;
        end
        else if (ready_stall > 0)
        begin
            out_ready   <= 1'b0;
            ready_stall <= ready_stall - 1;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            out_ready   <= 1'b0;
            ready_stall <= $urandom_range(0, 15);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // reset config: single-element tensor, every element is last at address zero
    task automatic test_reset_state();
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
        send_element(32'h5555_5555);
        send_element(32'hAAAA_AAAA);
    endtask

    task automatic test_small_transpose();
        reg_writes.push_back('{tasg_pkg::REG_RANK, CFG_DATA_W'(2)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS0, CFG_DATA_W'(2)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS1, CFG_DATA_W'(3)});
        program_regs();
        repeat (6) send_element($urandom());
    endtask

    task automatic test_negative_axes();
        reg_writes.push_back('{tasg_pkg::REG_SWAP_FIRST, CFG_DATA_W'(9'h1FF)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_SECOND, CFG_DATA_W'(9'h006)});
        program_regs();
        repeat (3) send_element($urandom());
    endtask

    task automatic test_axis_error();
        reg_writes.push_back('{tasg_pkg::REG_SWAP_FIRST, CFG_DATA_W'(3)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_SECOND, CFG_DATA_W'(4)});
        program_regs();
        repeat (2) send_element($urandom());
    endtask

    task automatic test_clamped_registers();
        reg_writes.push_back('{tasg_pkg::REG_RANK, CFG_DATA_W'(9'h1F8)});
        program_regs();
        repeat (2) send_element($urandom());
        reg_writes.push_back('{tasg_pkg::REG_RANK, CFG_DATA_W'(7)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS2, CFG_DATA_W'(0)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS3, CFG_DATA_W'(300)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_FIRST, CFG_DATA_W'(0)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_SECOND, CFG_DATA_W'(3)});
        program_regs();
        repeat (4) send_element($urandom());
    endtask

    task automatic test_largest_sizes();
        reg_writes.push_back('{tasg_pkg::REG_RANK, CFG_DATA_W'(4)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS0, CFG_DATA_W'(MAX_EXTENT)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS1, CFG_DATA_W'(MAX_EXTENT)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS2, CFG_DATA_W'(MAX_EXTENT)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS3, CFG_DATA_W'(MAX_EXTENT)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_FIRST, CFG_DATA_W'(1)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_SECOND, CFG_DATA_W'(2)});
        program_regs();
        repeat (3) send_element($urandom());
        // unmapped index: counter must keep running
        reg_writes.push_back('{REG_UNMAPPED, CFG_DATA_W'(9'h1AB)});
        program_regs();
        repeat (2) send_element($urandom());
    endtask

    task automatic test_output_backpressure();
        reg_writes.push_back('{tasg_pkg::REG_RANK, CFG_DATA_W'(3)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS0, CFG_DATA_W'(2)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS1, CFG_DATA_W'(3)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS2, CFG_DATA_W'(4)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_FIRST, CFG_DATA_W'(0)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_SECOND, CFG_DATA_W'(2)});
        program_regs();
        -> hold_start;
        repeat (40) send_element($urandom());
    endtask

    task automatic test_sender_pause();
        repeat (15) send_element($urandom());
        wait_drained();
        repeat (15) send_element($urandom());
    endtask

    task automatic test_random_phases();
        int                   sent;
        int                   n_items;
        logic [CFG_IDX_W-1:0] idx;
        longint               total;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4))
            begin
                idx = CFG_IDX_W'($urandom_range(0, 7));
                reg_writes.push_back('{idx, random_reg_value(idx)});
            end
            program_regs();
            total = tensor_elements();
            if (total <= 96)
                n_items = int'(total) * $urandom_range(1, 3) + $urandom_range(0, 2);
            else
                n_items = $urandom_range(4, 24);
            repeat (n_items) send_element($urandom());
            sent += n_items;
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        reg_writes.push_back('{tasg_pkg::REG_RANK, CFG_DATA_W'(3)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS0, CFG_DATA_W'(2)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS1, CFG_DATA_W'(2)});
        reg_writes.push_back('{tasg_pkg::REG_SIZE_AXIS2, CFG_DATA_W'(3)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_FIRST, CFG_DATA_W'(0)});
        reg_writes.push_back('{tasg_pkg::REG_SWAP_SECOND, CFG_DATA_W'(7)});
        program_regs();
        repeat (36) send_element($urandom());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        element_bits = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        shadow_rank   = tasg_pkg::RANK_RST;
        shadow_swap_a = tasg_pkg::SWAP_FIRST_RST;
        shadow_swap_b = tasg_pkg::SWAP_SECOND_RST;
        for (int i = 0; i < AXES; i++) shadow_size[i] = tasg_pkg::SIZE_RST;
        rebuild_strides();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_small_transpose();
        test_negative_axes();
        test_axis_error();
        test_clamped_registers();
        test_largest_sizes();
        test_output_backpressure();
        test_sender_pause();
        test_random_phases();
        test_steady_stream();

        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0 && dest_addr_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
